FILE: design/ntc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_pkg
// Types and codes shared by the numeric token type classifier modules.
// ----------------------------------------------------------------------------
package ntc_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] token_type;
    logic [4:0] number_base;
  } out_item_t;

  localparam logic [1:0] TT_INTEGRAL = 2'd0;
  localparam logic [1:0] TT_FLOATING = 2'd1;
  localparam logic [1:0] TT_STRING   = 2'd2;

  localparam logic [4:0] BASE_NONE = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  typedef enum logic [1:0] {
    OCT_START, OCT_ZERO, OCT_ACCEPT, OCT_DEAD
  } oct_state_t;

  typedef enum logic [1:0] {
    DEC_START, DEC_ZERO, DEC_INT, DEC_DEAD
  } dec_state_t;

  typedef enum logic [1:0] {
    HEX_PREFIX, HEX_X, HEX_ACCEPT, HEX_DEAD
  } hex_state_t;

  typedef enum logic [3:0] {
    F_START, F_SIGN, F_ZERO, F_INT, F_DIGS, F_FRAC, F_E, F_ESIGN,
    F_EXP, F_N1, F_NA, F_NAN, F_I1, F_IN, F_INF, F_DEAD
  } flt_state_t;

endpackage
`default_nettype wire

FILE: design/ntc_recognizers.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_recognizers
// Four token recognizers stepped one character at a time, with the
// classification of the token on its final item.
// ----------------------------------------------------------------------------
module ntc_recognizers
  import ntc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire in_item_t  item,
  output out_item_t      result
);

  oct_state_t oct_r, oct_nxt, oct_eff;
  dec_state_t dec_r, dec_nxt, dec_eff;
  hex_state_t hex_r, hex_nxt, hex_eff;
  flt_state_t flt_r, flt_nxt, flt_eff;

  logic [7:0] ch;
  logic [7:0] lc;
  logic       is_dig;
  logic       is_oct;
  logic       is_hex;
  logic       is_sign;
  logic       flt_ok;

  assign ch      = item.character;
  assign lc      = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'd32 : ch;
  assign is_dig  = (ch >= 8'h30 && ch <= 8'h39);
  assign is_oct  = (ch >= 8'h30 && ch <= 8'h37);
  assign is_hex  = is_dig || (lc >= 8'h61 && lc <= 8'h66);
  assign is_sign = (lc == 8'h2b) || (lc == 8'h2d);

  // Next state of every recognizer for the current character.
  always_comb begin
    unique case (oct_r)
      OCT_START:            oct_nxt = (ch == 8'h30) ? OCT_ZERO : OCT_DEAD;
      OCT_ZERO, OCT_ACCEPT: oct_nxt = is_oct ? OCT_ACCEPT : OCT_DEAD;
      default:              oct_nxt = OCT_DEAD;
    endcase

    unique case (dec_r)
      DEC_START: begin
        if (ch == 8'h30) dec_nxt = DEC_ZERO;
        else             dec_nxt = is_dig ? DEC_INT : DEC_DEAD;
      end
      DEC_INT: dec_nxt = is_dig ? DEC_INT : DEC_DEAD;
      default: dec_nxt = DEC_DEAD;
    endcase

    // The hex prefix progress is tracked by the decimal recognizer.
    unique case (hex_r)
      HEX_PREFIX: begin
        if (dec_r == DEC_START)     hex_nxt = (lc == 8'h30) ? HEX_PREFIX : HEX_DEAD;
        else if (dec_r == DEC_ZERO) hex_nxt = (lc == 8'h78) ? HEX_X : HEX_DEAD;
        else                        hex_nxt = HEX_DEAD;
      end
      HEX_X, HEX_ACCEPT: hex_nxt = is_hex ? HEX_ACCEPT : HEX_DEAD;
      default:           hex_nxt = HEX_DEAD;
    endcase

    flt_nxt = F_DEAD;
    unique case (flt_r)
      F_START, F_SIGN: begin
        if (flt_r == F_START && is_sign)      flt_nxt = F_SIGN;
        else if (flt_r == F_START && lc == 8'h6e) flt_nxt = F_N1;
        else if (flt_r == F_START && lc == 8'h69) flt_nxt = F_I1;
        else if (lc == 8'h30)                  flt_nxt = F_ZERO;
        else if (is_dig)                       flt_nxt = F_INT;
        else if (lc == 8'h2e)                  flt_nxt = F_FRAC;
        else if (lc == 8'h65)                  flt_nxt = F_E;
      end
      F_ZERO: begin
        if (is_dig)           flt_nxt = F_DIGS;
        else if (lc == 8'h2e) flt_nxt = F_FRAC;
        else if (lc == 8'h65) flt_nxt = F_E;
      end
      F_INT: begin
        if (is_dig)           flt_nxt = F_INT;
        else if (lc == 8'h2e) flt_nxt = F_FRAC;
        else if (lc == 8'h65) flt_nxt = F_E;
      end
      F_DIGS: begin
        if (is_dig)           flt_nxt = F_DIGS;
        else if (lc == 8'h65) flt_nxt = F_E;
      end
      F_FRAC: begin
        if (is_dig)           flt_nxt = F_FRAC;
        else if (lc == 8'h65) flt_nxt = F_E;
      end
      F_E: begin
        if (is_sign)     flt_nxt = F_ESIGN;
        else if (is_dig) flt_nxt = F_EXP;
      end
      F_ESIGN, F_EXP: if (is_dig) flt_nxt = F_EXP;
      F_N1:    if (lc == 8'h61) flt_nxt = F_NA;
      F_NA:    if (lc == 8'h6e) flt_nxt = F_NAN;
      F_I1:    if (lc == 8'h6e) flt_nxt = F_IN;
      F_IN:    if (lc == 8'h66) flt_nxt = F_INF;
      default: flt_nxt = F_DEAD;
    endcase
  end

  // Classification from the states that include this item's character.
  always_comb begin
    oct_eff = item.has_char ? oct_nxt : oct_r;
    dec_eff = item.has_char ? dec_nxt : dec_r;
    hex_eff = item.has_char ? hex_nxt : hex_r;
    flt_eff = item.has_char ? flt_nxt : flt_r;

    flt_ok = (flt_eff == F_START) || (flt_eff == F_SIGN) || (flt_eff == F_ZERO) ||
             (flt_eff == F_INT) || (flt_eff == F_DIGS) || (flt_eff == F_FRAC) ||
             (flt_eff == F_EXP) || (flt_eff == F_NAN) || (flt_eff == F_INF);

    priority if (oct_eff == OCT_ACCEPT) begin
      result = '{token_type: TT_INTEGRAL, number_base: BASE_OCT};
    end else if (dec_eff == DEC_ZERO || dec_eff == DEC_INT) begin
      result = '{token_type: TT_INTEGRAL, number_base: BASE_DEC};
    end else if (hex_eff == HEX_ACCEPT) begin
      result = '{token_type: TT_INTEGRAL, number_base: BASE_HEX};
    end else if (flt_ok) begin
      result = '{token_type: TT_FLOATING, number_base: BASE_NONE};
    end else begin
      result = '{token_type: TT_STRING, number_base: BASE_NONE};
    end
  end

  // The final item of a token returns every recognizer to its start state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r <= OCT_START;
      dec_r <= DEC_START;
      hex_r <= HEX_PREFIX;
      flt_r <= F_START;
    end else if (step) begin
      if (item.last) begin
        oct_r <= OCT_START;
        dec_r <= DEC_START;
        hex_r <= HEX_PREFIX;
        flt_r <= F_START;
      end else if (item.has_char) begin
        oct_r <= oct_nxt;
        dec_r <= dec_nxt;
        hex_r <= hex_nxt;
        flt_r <= flt_nxt;
      end
    end
  end

`ifndef SYNTH
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last |=> oct_r == OCT_START && dec_r == DEC_START &&
                          hex_r == HEX_PREFIX && flt_r == F_START)
    else $error("recognizers not restarted after final item");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.has_char && !item.last |=>
      $stable(oct_r) && $stable(dec_r) && $stable(hex_r) && $stable(flt_r))
    else $error("recognizer state changed on an item without a character");

  a_dead_stays: assert property (@(posedge clk) disable iff (!rst_n)
    !item.last && oct_r == OCT_DEAD && flt_r == F_DEAD |=>
      oct_r == OCT_DEAD && flt_r == F_DEAD)
    else $error("dead recognizer revived inside a token");
`endif

endmodule
`default_nettype wire

FILE: design/numeric_token_type_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// numeric_token_type_classifier_unit
// Classifies a streamed text token as integral (with base), floating or string.
// ----------------------------------------------------------------------------
// Usage:
//   A token enters on the in_ channel one character per transfer; in_data.last
//   marks its final transfer. A final transfer with has_char clear and no
//   characters before it is the empty token. Transfers without last give no
//   result; each final transfer gives exactly one result on the out_ channel.
//   A transfer taken lands in the input register; when it moves on it steps
//   the recognizers and, if final, its result is captured in the result
//   register that drives out_valid.
//   Throughput: one character per cycle while out_ready stays high; the rate
//   is set by the single input register feeding the recognizer update.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops once both are occupied.
//   Reset (rst_n low, synchronous) empties both registers and returns all
//   recognizers to their start states.
// ----------------------------------------------------------------------------
module numeric_token_type_classifier_unit
  import ntc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      s1_adv;
  out_item_t result;

  // The staged item moves on whenever the result register is free or draining.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  ntc_recognizers u_recog (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item_r.last) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTH
  a_int_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.token_type == TT_INTEGRAL |->
      out_item_r.number_base == BASE_OCT || out_item_r.number_base == BASE_DEC ||
      out_item_r.number_base == BASE_HEX)
    else $error("integral result without a valid base");

  a_other_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.token_type != TT_INTEGRAL |->
      out_item_r.number_base == BASE_NONE)
    else $error("non-integral result with a nonzero base");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !(s1_adv && s1_item_r.last) |=> !out_valid_r)
    else $error("result repeated after its transfer");
`endif

endmodule
`default_nettype wire

FILE: tb/ntc_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_token_checker
// Watches both channels of the numeric token type classifier. It follows the
// characters of each token with its own four recognizers, queues the expected
// classification at the end of each token and compares every result transfer
// against the oldest queued classification.
// ----------------------------------------------------------------------------
module ntc_token_checker
  import ntc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_results
);

  oct_state_t oct_st;
  dec_state_t dec_st;
  hex_state_t hex_st;
  flt_state_t flt_st;

  out_item_t expected_classes[$];
  int        mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  // Start of the mantissa, shared by the start state and the state after a sign.
  function automatic flt_state_t float_mantissa(logic [7:0] lc);
    if (lc == "0") return F_ZERO;
    if (is_digit(lc)) return F_INT;
    if (lc == ".") return F_FRAC;
    if (lc == "e") return F_E;
    return F_DEAD;
  endfunction

  function automatic flt_state_t float_advance(flt_state_t s, logic [7:0] lc);
    bit d;
    d = is_digit(lc);
    case (s)
      F_START: begin
        if (is_sign(lc)) return F_SIGN;
        if (lc == "n") return F_N1;
        if (lc == "i") return F_I1;
        return float_mantissa(lc);
      end
      F_SIGN: return float_mantissa(lc);
      F_ZERO: begin
        if (d) return F_DIGS;
        if (lc == ".") return F_FRAC;
        if (lc == "e") return F_E;
        return F_DEAD;
      end
      F_INT: begin
        if (d) return F_INT;
        if (lc == ".") return F_FRAC;
        if (lc == "e") return F_E;
        return F_DEAD;
      end
      F_DIGS: begin
        if (d) return F_DIGS;
        return (lc == "e") ? F_E : F_DEAD;
      end
      F_FRAC: begin
        if (d) return F_FRAC;
        return (lc == "e") ? F_E : F_DEAD;
      end
      F_E: begin
        if (is_sign(lc)) return F_ESIGN;
        return d ? F_EXP : F_DEAD;
      end
      F_ESIGN, F_EXP: return d ? F_EXP : F_DEAD;
      F_N1: return (lc == "a") ? F_NA : F_DEAD;
      F_NA: return (lc == "n") ? F_NAN : F_DEAD;
      F_I1: return (lc == "n") ? F_IN : F_DEAD;
      F_IN: return (lc == "f") ? F_INF : F_DEAD;
      default: return F_DEAD;
    endcase
  endfunction

  function automatic bit float_accepting(flt_state_t s);
    return s inside {F_START, F_SIGN, F_ZERO, F_INT, F_DIGS, F_FRAC, F_EXP,
                     F_NAN, F_INF};
  endfunction

  task automatic clear_recognizers();
    oct_st = OCT_START;
    dec_st = DEC_START;
    hex_st = HEX_PREFIX;
    flt_st = F_START;
  endtask

  task automatic absorb_char(logic [7:0] c);
    logic [7:0] lc;
    dec_state_t dec_prev;
    lc = fold_case(c);
    dec_prev = dec_st;

    case (oct_st)
      OCT_START: oct_st = (c == "0") ? OCT_ZERO : OCT_DEAD;
      OCT_ZERO, OCT_ACCEPT: oct_st = (c >= "0" && c <= "7") ? OCT_ACCEPT : OCT_DEAD;
      default: oct_st = OCT_DEAD;
    endcase

    case (dec_st)
      DEC_START: dec_st = (c == "0") ? DEC_ZERO : (is_digit(c) ? DEC_INT : DEC_DEAD);
      DEC_INT: dec_st = is_digit(c) ? DEC_INT : DEC_DEAD;
      default: dec_st = DEC_DEAD;
    endcase

    // The hex prefix tracks "0x" through the decimal recognizer's previous state.
    case (hex_st)
      HEX_PREFIX: begin
        if (dec_prev == DEC_START) hex_st = (lc == "0") ? HEX_PREFIX : HEX_DEAD;
        else if (dec_prev == DEC_ZERO) hex_st = (lc == "x") ? HEX_X : HEX_DEAD;
        else hex_st = HEX_DEAD;
      end
      HEX_X, HEX_ACCEPT: begin
        hex_st = (is_digit(lc) || (lc >= "a" && lc <= "f")) ? HEX_ACCEPT : HEX_DEAD;
      end
      default: hex_st = HEX_DEAD;
    endcase

    flt_st = float_advance(flt_st, lc);
  endtask

  function automatic out_item_t token_class();
    out_item_t v;
    if (oct_st == OCT_ACCEPT) begin
      v = '{token_type: TT_INTEGRAL, number_base: BASE_OCT};
    end else if (dec_st == DEC_ZERO || dec_st == DEC_INT) begin
      v = '{token_type: TT_INTEGRAL, number_base: BASE_DEC};
    end else if (hex_st == HEX_ACCEPT) begin
      v = '{token_type: TT_INTEGRAL, number_base: BASE_HEX};
    end else if (float_accepting(flt_st)) begin
      v = '{token_type: TT_FLOATING, number_base: BASE_NONE};
    end else begin
      v = '{token_type: TT_STRING, number_base: BASE_NONE};
    end
    return v;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_recognizers();
      expected_classes.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.has_char) absorb_char(in_data.character);
        if (in_data.last) begin
          expected_classes.push_back(token_class());
          clear_recognizers();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_classes.size() == 0) begin
          $error("result transfer with no token outstanding: type %0d base %0d",
                 out_data.token_type, out_data.number_base);
          mismatches++;
        end else begin
          want = expected_classes.pop_front();
          if (out_data.token_type !== want.token_type) begin
            $error("token_type mismatch: expected %0d, actual %0d",
                   want.token_type, out_data.token_type);
            mismatches++;
          end
          if (out_data.number_base !== want.number_base) begin
            $error("number_base mismatch: expected %0d, actual %0d",
                   want.number_base, out_data.number_base);
            mismatches++;
          end
        end
      end
    end
    pending_results <= expected_classes.size();
  end

endmodule

FILE: tb/tb_numeric_token_type_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_numeric_token_type_classifier_unit
// Streams text tokens into the classifier: a directed set covering each
// number form, nan and inf, the empty token and odd bytes, then random tokens,
// mostly well-formed numbers with random content plus mutated and noise
// tokens. Both sides idle at random; the receiver also holds off for a long
// stretch and the sender pauses once mid-run to drain. A checker module judges the results.
// ----------------------------------------------------------------------------
module tb_numeric_token_type_classifier_unit;
  import ntc_pkg::*;

  localparam int    RANDOM_ITEMS = 900;
  localparam string ALPHABET     = "0123456789abcdefxXeEnNaAiIfF+-.";
  localparam string HEX_DIGITS   = "0123456789abcdefABCDEF";

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending_results;

  bit         calm = 0;
  int         stall_cycles = 0;
  int         items_sent = 0;
  logic [7:0] token_chars[$];

  numeric_token_type_classifier_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ntc_token_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off counted down here.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        out_ready <= 1'b0;
        stall_cycles--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_item(logic [7:0] c, bit has_char, bit last);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{character: c, has_char: has_char, last: last};
    do @(posedge clk); while (!in_ready);
    if (has_char || last) items_sent++;
  endtask

  // Sends the queued characters as one token, optionally closing it with a
  // final transfer that carries no character.
  task automatic send_token(bit end_empty, bit with_noise);
    int n;
    n = token_chars.size();
    for (int i = 0; i < n; i++) begin
      if (with_noise && $urandom_range(11) == 0) send_item(8'($urandom_range(255)), 0, 0);
      send_item(token_chars[i], 1, (i == n - 1) && !end_empty);
    end
    if (n == 0 || end_empty) send_item(8'($urandom_range(255)), 0, 1);
    token_chars.delete();
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1)) return c - 8'd32;
    return c;
  endfunction

  task automatic push_text(string s, bit mix_case);
    for (int i = 0; i < s.len(); i++)
      token_chars.push_back(mix_case ? any_case(s[i]) : s[i]);
  endtask

  task automatic push_digits(int n, int top);
    repeat (n) token_chars.push_back(8'h30 + 8'($urandom_range(top)));
  endtask

  task automatic push_sign();
    token_chars.push_back($urandom_range(1) ? "+" : "-");
  endtask

  task automatic build_float();
    if ($urandom_range(2) == 0) push_sign();
    case ($urandom_range(3))
      0: push_text("0.", 0);
      1: begin
        token_chars.push_back(8'h30 + 8'($urandom_range(1, 9)));
        push_digits($urandom_range(3), 9);
        if ($urandom_range(1)) push_text(".", 0);
      end
      2: push_text(".", 0);
      default: ;
    endcase
    push_digits($urandom_range(3), 9);
    if ($urandom_range(1)) begin
      token_chars.push_back(any_case("e"));
      if ($urandom_range(1)) push_sign();
      // An exponent without digits is occasionally left to make a string.
      push_digits($urandom_range(($urandom_range(7) == 0) ? 0 : 1, 3), 9);
    end
  endtask

  task automatic build_token();
    int kind;
    int pos;
    kind = $urandom_range(19);
    if (kind <= 2) begin
      push_text("0", 0);
      push_digits($urandom_range(1, 5), 7);
    end else if (kind <= 5) begin
      if ($urandom_range(3) == 0) push_text("0", 0);
      else begin
        token_chars.push_back(8'h30 + 8'($urandom_range(1, 9)));
        push_digits($urandom_range(5), 9);
      end
    end else if (kind <= 8) begin
      push_text("0x", 1);
      repeat ($urandom_range(1, 5))
        token_chars.push_back(HEX_DIGITS[$urandom_range(HEX_DIGITS.len() - 1)]);
    end else if (kind <= 13) begin
      build_float();
    end else if (kind <= 15) begin
      if ($urandom_range(3) == 0) push_sign();
      push_text($urandom_range(1) ? "nan" : "inf", 1);
    end else if (kind <= 17) begin
      repeat ($urandom_range(1, 6))
        token_chars.push_back(ALPHABET[$urandom_range(ALPHABET.len() - 1)]);
    end else if (kind == 18) begin
      repeat ($urandom_range(1, 4)) token_chars.push_back(8'($urandom_range(255)));
    end
    // Now and then a well-formed token gets one character corrupted.
    if (kind <= 15 && token_chars.size() > 0 && $urandom_range(7) == 0) begin
      pos = $urandom_range(token_chars.size() - 1);
      token_chars[pos] = $urandom_range(1) ? ALPHABET[$urandom_range(ALPHABET.len() - 1)]
                                           : 8'($urandom_range(255));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    hold_done  = 0;
    drain_done = 0;
    rst_n    = 0;
    in_valid = 0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed tokens.
    send_token(0, 0);                       // empty token
    push_text("0", 0);    send_token(0, 0);
    push_text("07", 0);   send_token(0, 0);
    push_text("08", 0);   send_token(0, 0);
    push_text("0xF", 0);  send_token(0, 0);
    push_text("nan", 0);  send_token(0, 0);
    push_text("Inf", 0);  send_token(0, 0);
    push_text("-.e9", 0); send_token(0, 0);
    // A skipped transfer inside a token, then an end with no character.
    send_item("1", 1, 0);
    send_item(8'hA5, 0, 0);
    send_item("2", 1, 0);
    send_item(8'h00, 0, 1);
    send_item(8'h00, 1, 1);                 // zero byte
    send_item(8'hFF, 1, 1);                 // byte above the ASCII range

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= 250) begin
        stall_cycles = 300;
        hold_done = 1;
      end
      if (!drain_done && items_sent >= 650) begin
        drain_results();
        drain_done = 1;
      end
      calm = (items_sent >= 400 && items_sent < 540);
      build_token();
      send_token($urandom_range(7) == 0, 1);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ntc_pkg.sv
design/ntc_recognizers.sv
design/numeric_token_type_classifier_unit.sv
tb/ntc_token_checker.sv
tb/tb_numeric_token_type_classifier_unit.sv
